// ----- rtl/doy2unix_pkg.sv -----
// ----------------------------------------------------------------------------
// doy2unix_pkg
// Shared types, constants and calendar tables for the day-of-year to Unix
// seconds converter.
// ----------------------------------------------------------------------------
`default_nettype none

package doy2unix_pkg;

  localparam int YEAR_W = 12;   // 1900..2155
  localparam int DAY_W  = 10;   // day of year plus one, up to 512
  localparam int MON_W  = 4;
  localparam int DAYS_W = 20;   // signed day count relative to the epoch
  localparam int TOD_W  = 17;   // time of day in seconds, up to 115443
  localparam int SEC_W  = 40;   // signed seconds before saturation

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_SAT   = 2'd2;

  localparam logic [MON_W-1:0] MON_FEB  = MON_W'(1);
  localparam logic [MON_W-1:0] MON_MAR  = MON_W'(2);
  localparam logic [MON_W-1:0] MON_LAST = MON_W'(11);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DAYS,
    S_MUL,
    S_SUM,
    S_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic calc_days;
    logic calc_mul;
    logic calc_sum;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
    logic walk_over;
    logic out_free;
  } stat_t;

  // Length of a month in a common year (February fixed up by the caller).
  function automatic logic [4:0] month_len(input logic [MON_W-1:0] mon);
    logic [4:0] len;
    unique case (mon)
      4'd1:                      len = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // floor(30.6001 * (m + 1)) with March as the first month of the counting
  // year; January and February map to months 13 and 14.
  function automatic logic [8:0] month_term(input logic [MON_W-1:0] mon);
    logic [8:0] t;
    unique case (mon)
      4'd0:    t = 9'd428;
      4'd1:    t = 9'd459;
      4'd2:    t = 9'd122;
      4'd3:    t = 9'd153;
      4'd4:    t = 9'd183;
      4'd5:    t = 9'd214;
      4'd6:    t = 9'd244;
      4'd7:    t = 9'd275;
      4'd8:    t = 9'd306;
      4'd9:    t = 9'd336;
      4'd10:   t = 9'd367;
      default: t = 9'd397;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/doy2unix_dp.sv -----
// ----------------------------------------------------------------------------
// doy2unix_dp
// Datapath: month walk, day number, scaling to seconds, rounding,
// saturation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module doy2unix_dp (
  input  wire                  clk,
  input  wire                  rst,
  input  doy2unix_pkg::cmd_t   cmd,
  output doy2unix_pkg::stat_t  stat,
  input  wire  [7:0]           year_since_1900,
  input  wire  [8:0]           day_of_year,
  input  wire  [4:0]           hour,
  input  wire  [5:0]           minute,
  input  wire  [5:0]           second,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic signed [31:0]   unix_seconds,
  output logic [1:0]           status
);
  import doy2unix_pkg::*;

  localparam logic signed [SEC_W-1:0] SMAX = SEC_W'(2147483647);
  localparam logic signed [SEC_W-1:0] SMIN = -SMAX - SEC_W'(1);

  logic [YEAR_W-1:0]        year;
  logic [DAY_W-1:0]         day;
  logic [MON_W-1:0]         mon;
  logic [4:0]               hr;
  logic [5:0]               mi;
  logic [5:0]               se;
  logic                     err;
  logic signed [DAYS_W-1:0] days;
  logic [TOD_W-1:0]         tod;
  logic signed [SEC_W-1:0]  prod;
  logic signed [SEC_W-1:0]  secs;

  logic                     leap;
  logic [4:0]               len;
  logic [YEAR_W-1:0]        y;
  logic signed [4:0]        b;
  logic [22:0]              y1461;
  logic signed [21:0]       c;
  logic signed [DAYS_W-1:0] days_next;
  logic [TOD_W-1:0]         tod_next;
  logic signed [SEC_W-1:0]  rounded;
  logic signed [31:0]       sat_val;
  logic                     sat;

  // Only 1900 and 2100 are non-leap multiples of four in the input range.
  assign leap = (year[1:0] == 2'b00) && (year != YEAR_W'(1900)) && (year != YEAR_W'(2100));
  assign len  = (mon == MON_FEB) ? (leap ? 5'd29 : 5'd28) : month_len(mon);

  assign stat.walk_done = (day <= DAY_W'(len));
  assign stat.walk_over = !stat.walk_done && (mon == MON_LAST);
  assign stat.out_free  = !out_valid || !out_stall;

  // Counting year starts in March.
  assign y = (mon < MON_MAR) ? year - YEAR_W'(1) : year;

  // Century correction 2 - a + a/4 for a = y/100, y in 1899..2155.
  always_comb begin
    if (y < YEAR_W'(1900)) begin
      b = -5'sd12;
    end else if (y < YEAR_W'(2100)) begin
      b = -5'sd13;
    end else begin
      b = -5'sd14;
    end
  end

  assign y1461 = 23'(y) * 23'd1461;
  assign c     = $signed({1'b0, y1461[22:2]}) - 22'sd694025;

  assign days_next = DAYS_W'(b) + DAYS_W'(c) + DAYS_W'(month_term(mon)) + DAYS_W'(day)
                   - DAYS_W'(25568);
  assign tod_next  = TOD_W'(hr) * TOD_W'(3600) + TOD_W'(mi) * TOD_W'(60) + TOD_W'(se);

  // Half-second rounding then truncation: negative totals move up by one.
  assign rounded = secs[SEC_W-1] ? secs + SEC_W'(1) : secs;

  always_comb begin
    sat     = 1'b0;
    sat_val = rounded[31:0];
    if (rounded > SMAX) begin
      sat     = 1'b1;
      sat_val = SMAX[31:0];
    end else if (rounded < SMIN) begin
      sat     = 1'b1;
      sat_val = SMIN[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      year <= YEAR_W'(year_since_1900) + YEAR_W'(1900);
      day  <= DAY_W'(day_of_year) + DAY_W'(1);
      mon  <= '0;
      hr   <= hour;
      mi   <= minute;
      se   <= second;
      err  <= 1'b0;
    end else if (cmd.step && !stat.walk_done) begin
      if (mon == MON_LAST) begin
        err <= 1'b1;
      end else begin
        day <= day - DAY_W'(len);
        mon <= mon + MON_W'(1);
      end
    end
    if (cmd.calc_days) begin
      days <= days_next;
      tod  <= tod_next;
    end
    if (cmd.calc_mul) begin
      prod <= SEC_W'(days) * SEC_W'(86400);
    end
    if (cmd.calc_sum) begin
      secs <= prod + SEC_W'($signed({1'b0, tod}));
    end
    if (cmd.finish) begin
      if (err) begin
        unix_seconds <= '0;
        status       <= STATUS_RANGE;
      end else begin
        unix_seconds <= sat_val;
        status       <= sat ? STATUS_SAT : STATUS_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/doy2unix_ctrl.sv -----
// ----------------------------------------------------------------------------
// doy2unix_ctrl
// Controller: sequences load, month walk, day number, multiply, sum and
// result write-back for one request at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module doy2unix_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  output doy2unix_pkg::cmd_t   cmd,
  input  doy2unix_pkg::stat_t  stat
);
  import doy2unix_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // No request is taken while reset is held.
  assign in_stall = rst || (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        cmd.step = 1'b1;
        if (stat.walk_done) begin
          state_next = S_DAYS;
        end else if (stat.walk_over) begin
          state_next = S_FIN;
        end
      end
      S_DAYS: begin
        cmd.calc_days = 1'b1;
        state_next    = S_MUL;
      end
      S_MUL: begin
        cmd.calc_mul = 1'b1;
        state_next   = S_SUM;
      end
      S_SUM: begin
        cmd.calc_sum = 1'b1;
        state_next   = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_accept_walk: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_WALK))
    else $error("accepted request did not start the month walk");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> stat.out_free)
    else $error("result written while output register still held");

  a_over_fin: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && stat.walk_over) |=> (state == S_FIN))
    else $error("day past year end did not go to write-back");

endmodule

`default_nettype wire

// ----- rtl/day_of_year_to_unix_seconds.sv -----
// ----------------------------------------------------------------------------
// day_of_year_to_unix_seconds
// UTC year/day-of-year/time to signed 32-bit Unix seconds, Gregorian rule,
// saturating, with day-past-year-end and saturation status.
//
//   channel  signals                                       direction
//   in       in_valid, in_stall, year_since_1900,
//            day_of_year, hour, minute, second              request in
//   out      out_valid, out_stall, unix_seconds, status     result out
//
// One request at a time: accept, then the month walk (one month per cycle),
// then day number, multiply, sum and write-back. A day past year end skips
// straight to write-back.
// The output register holds a result under out_stall while the next request
// is already accepted and worked on. Reset (rst, synchronous) empties it.
// ----------------------------------------------------------------------------
`default_nettype none

module day_of_year_to_unix_seconds (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  [7:0]         year_since_1900,
  input  wire  [8:0]         day_of_year,
  input  wire  [4:0]         hour,
  input  wire  [5:0]         minute,
  input  wire  [5:0]         second,
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [31:0] unix_seconds,
  output logic [1:0]         status
);
  import doy2unix_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  doy2unix_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  doy2unix_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .year_since_1900 (year_since_1900),
    .day_of_year     (day_of_year),
    .hour            (hour),
    .minute          (minute),
    .second          (second),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .unix_seconds    (unix_seconds),
    .status          (status)
  );

endmodule

`default_nettype wire
